FILE: hw/rtl/binned_min_max_mean_accumulator_top_defines.svh
// assertion macros for the binned statistics accumulator checker
// used by bmmma_checker; no other dependencies
`ifndef BINNED_MIN_MAX_MEAN_ACCUMULATOR_TOP_DEFINES_SVH
`define BINNED_MIN_MAX_MEAN_ACCUMULATOR_TOP_DEFINES_SVH

// same-cycle implication, clocked and reset-gated
`define BMMMA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmmma same-cycle check failed");

// next-cycle implication, clocked and reset-gated
`define BMMMA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmmma next-cycle check failed");

`endif

FILE: hw/rtl/bmmma_pkg.sv
// shared types and constants for the binned statistics accumulator
// no dependencies
`default_nettype none

package bmmma_pkg;

   // default configuration of the bin layout
   localparam int AZIMUTH_BIN_COUNT_DEF = 65536;
   localparam int BEAM_COUNT_DEF        = 2;
   localparam int PULSES_PER_FRAME_DEF  = 100;
   localparam int PULSE_FLAG_COUNT_DEF  = 13;

   // fixed field widths
   localparam int DN_W    = 32;
   localparam int COUNT_W = 32;
   localparam int SUM_W   = 64;
   localparam int ENTRY_W = COUNT_W + SUM_W + 2 * DN_W;

   // depth of the front-to-back queue
   localparam int QDEPTH = 2;

   // operation codes
   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_READ       = 1'b1;

   // register indexes
   localparam logic CSR_ALLOW_ERRORS = 1'b0;
   localparam logic CSR_WANTED_MODE  = 1'b1;

   // one classified item handed to the back end
   typedef struct packed {
      logic            op;
      logic            ok;
      logic [DN_W-1:0] dn;
   } item_type;

   // one stored bin
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [SUM_W-1:0]   sum;
      logic [DN_W-1:0]    min;
      logic [DN_W-1:0]    max;
   } entry_type;

endpackage

`default_nettype wire

FILE: hw/rtl/bmmma_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module bmmma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/bmmma_div.sv
// radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle
// depends on bmmma_pkg
`default_nettype none

module bmmma_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [bmmma_pkg::SUM_W-1:0]   dividend,
   input  wire logic [bmmma_pkg::COUNT_W-1:0] divisor,
   output logic                              done,
   output logic      [bmmma_pkg::SUM_W-1:0]   quotient
);
   import bmmma_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]     quot_ff, quot_in;
   logic [COUNT_W-1:0]   div_ff, div_in;
   logic [COUNT_W:0]     rem_sh;
   logic [COUNT_W:0]     diff;
   logic                 ge;

   // one quotient bit per step
   always_comb begin
      rem_sh  = {rem_ff, quot_ff[SUM_W-1]};
      diff    = rem_sh - {1'b0, div_ff};
      ge      = rem_sh >= {1'b0, div_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      div_in  = div_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quot_in = dividend;
         div_in  = divisor;
      end else if (run_ff) begin
         rem_in  = ge ? diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
         quot_in = {quot_ff[SUM_W-2:0], ge};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bmmma_front.sv
// front end: configuration registers, pulse qualification, bin address, queue
// depends on bmmma_pkg
`default_nettype none

module bmmma_front #(
   parameter int AZIMUTH_BIN_COUNT = bmmma_pkg::AZIMUTH_BIN_COUNT_DEF,
   parameter int BEAM_COUNT        = bmmma_pkg::BEAM_COUNT_DEF,
   parameter int PULSES_PER_FRAME  = bmmma_pkg::PULSES_PER_FRAME_DEF,
   parameter int PULSE_FLAG_COUNT  = bmmma_pkg::PULSE_FLAG_COUNT_DEF,
   parameter int ADDR_W            = 17
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   output logic                            full,
   input  wire logic                       csr_we,
   input  wire logic                       csr_index,
   input  wire logic [7:0]                 csr_wdata,
   input  wire logic                       op,
   input  wire logic [6:0]                 pulse_index,
   input  wire logic [15:0]                azimuth,
   input  wire logic [31:0]                noise_energy,
   input  wire logic signed [7:0]          cal_pulse_pos,
   input  wire logic [31:0]                frame_error,
   input  wire logic [15:0]                frame_quality,
   input  wire logic [12:0]                pulse_flag_mask,
   input  wire logic [7:0]                 frame_mode,
   input  wire logic                       read_beam,
   output logic                            q_valid,
   input  wire logic                       q_pop,
   output bmmma_pkg::item_type             q_item,
   output logic      [ADDR_W-1:0]          q_addr
);
   import bmmma_pkg::*;

   localparam int AZW = $clog2(AZIMUTH_BIN_COUNT);
   localparam int BW  = ADDR_W - AZW;
   localparam int PW  = $clog2(QDEPTH);
   localparam int CW  = $clog2(QDEPTH + 1);
   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / AZIMUTH_BIN_COUNT + 1);
   localparam logic [16:0] AZ_N  = 17'(AZIMUTH_BIN_COUNT);
   localparam logic [12:0] FLAG_MASK =
      (PULSE_FLAG_COUNT >= 13) ? 13'h1fff : 13'((1 << PULSE_FLAG_COUNT) - 1);

   logic [BW-1:0]    beam_lut [128];
   logic             allow_ff;
   logic [7:0]       mode_ff;
   logic             bad_err, bad_flag, bad_mode, bad_idx, bad_cal;
   logic [8:0]       p9, c9;
   logic [48:0]      q_prod;
   logic [32:0]      r_prod;
   logic [15:0]      r_full;
   logic             s_valid_ff;
   item_type         s_item_ff, s_item_in;
   logic [BW-1:0]    s_beam_ff, s_beam_in;
   logic [15:0]      s_az_ff;
   logic [15:0]      s_q_ff;
   item_type         qi_ff [QDEPTH];
   logic [ADDR_W-1:0] qa_ff [QDEPTH];
   logic [PW-1:0]    wp_ff, rp_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;

   // beam of each pulse position, worked out at elaboration
   for (genvar g = 0; g < 128; g++) begin : g_beam
      assign beam_lut[g] = BW'(g % BEAM_COUNT);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         allow_ff <= 1'b0;
         mode_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ALLOW_ERRORS: allow_ff <= csr_wdata[0];
            CSR_WANTED_MODE:  mode_ff  <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // pulse qualification
   always_comb begin
      p9       = {2'b00, pulse_index};
      c9       = {cal_pulse_pos[7], cal_pulse_pos};
      bad_err  = !allow_ff && ((frame_error != '0) || (frame_quality != '0));
      bad_flag = (pulse_flag_mask & FLAG_MASK) != '0;
      bad_mode = frame_mode != mode_ff;
      bad_idx  = {1'b0, pulse_index} >= 8'(PULSES_PER_FRAME);
      bad_cal  = (p9 == c9) || (p9 == c9 - 9'd1);
      s_item_in.op = op;
      s_item_in.ok = !(bad_err || bad_flag || bad_mode || bad_idx || bad_cal);
      s_item_in.dn = noise_energy;
      s_beam_in    = (op == OP_READ) ? beam_lut[{6'b0, read_beam}] : beam_lut[pulse_index];
      q_prod       = {33'b0, azimuth} * {16'b0, RECIP};
   end

   // first stage: quotient of azimuth by bin count
   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s_item_ff <= s_item_in;
         s_beam_ff <= s_beam_in;
         s_az_ff   <= azimuth;
         s_q_ff    <= q_prod[47:32];
      end
   end

   // second stage: remainder forms the bin address
   always_comb begin
      r_prod = 33'(s_q_ff) * 33'(AZ_N);
      r_full = s_az_ff - r_prod[15:0];
   end

   // queue toward the back end
   always_comb begin
      cnt_in = cnt_ff;
      if (s_valid_ff && !q_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (!s_valid_ff && q_pop) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (s_valid_ff) begin
            wp_ff <= wp_ff + PW'(1);
         end
         if (q_pop) begin
            rp_ff <= rp_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s_valid_ff) begin
         qi_ff[wp_ff] <= s_item_ff;
         qa_ff[wp_ff] <= {s_beam_ff, r_full[AZW-1:0]};
      end
   end

   // room counts the item in the first stage as well
   assign full    = (cnt_ff == CW'(QDEPTH)) || ((cnt_ff == CW'(QDEPTH - 1)) && s_valid_ff);
   assign q_valid = cnt_ff != '0;
   assign q_item  = qi_ff[rp_ff];
   assign q_addr  = qa_ff[rp_ff];

endmodule

`default_nettype wire

FILE: hw/rtl/bmmma_back.sv
// back end: bin memory, clearing pass, read-modify-write and bin reads
// depends on bmmma_pkg, bmmma_ram, bmmma_div
`default_nettype none

module bmmma_back #(
   parameter int ADDR_W = 17
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   output logic                        clearing,
   input  wire logic                   q_valid,
   output logic                        q_pop,
   input  wire bmmma_pkg::item_type    q_item,
   input  wire logic [ADDR_W-1:0]      q_addr,
   output logic                        rsp_valid,
   output logic                        rsp_accepted,
   output logic                        rsp_bin_has_data,
   output logic [31:0]                 rsp_bin_count,
   output logic [31:0]                 rsp_bin_min,
   output logic [31:0]                 rsp_bin_max,
   output logic [63:0]                 rsp_bin_sum,
   output logic [31:0]                 rsp_bin_average
);
   import bmmma_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   item_type          cur_ff, cur_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   entry_type         rd;
   logic [ENTRY_W-1:0] rdata;
   entry_type         wr;
   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic              first;
   logic [SUM_W:0]    nsum;
   logic              div_start, div_done;
   logic [SUM_W-1:0]  div_quot;
   entry_type         hold_ff, hold_in;
   logic              ov_ff, ov_in;
   logic              acc_ff, acc_in;
   logic              has_ff, has_in;
   entry_type         out_ff, out_in;
   logic [31:0]       avg_ff, avg_in;

   bmmma_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (we),
      .waddr(waddr),
      .wdata(wr),
      .raddr(q_addr),
      .rdata(rdata)
   );

   bmmma_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(rd.sum),
      .divisor (rd.count),
      .done    (div_done),
      .quotient(div_quot)
   );

   // sequencer
   always_comb begin
      rd        = rdata;
      first     = rd.count == '0;
      nsum      = {1'b0, rd.sum} + {{(SUM_W - DN_W + 1){1'b0}}, cur_ff.dn};
      state_in  = state_ff;
      clr_in    = clr_ff;
      cur_in    = cur_ff;
      addr_in   = addr_ff;
      hold_in   = hold_ff;
      q_pop     = 1'b0;
      we        = 1'b0;
      waddr     = addr_ff;
      wr        = '0;
      div_start = 1'b0;
      ov_in     = 1'b0;
      acc_in    = 1'b0;
      has_in    = 1'b0;
      out_in    = '0;
      avg_in    = '0;
      unique case (state_ff)
         S_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               cur_in  = q_item;
               addr_in = q_addr;
               if (q_item.op == OP_ACCUMULATE && !q_item.ok) begin
                  // rejected pulse answers without a bin read
                  ov_in = 1'b1;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            if (cur_ff.op == OP_ACCUMULATE) begin
               // update bin
               we       = 1'b1;
               wr.count = (rd.count == '1) ? rd.count : rd.count + COUNT_W'(1);
               wr.sum   = nsum[SUM_W] ? '1 : nsum[SUM_W-1:0];
               wr.min   = (first || cur_ff.dn < rd.min) ? cur_ff.dn : rd.min;
               wr.max   = (first || cur_ff.dn > rd.max) ? cur_ff.dn : rd.max;
               ov_in    = 1'b1;
               acc_in   = 1'b1;
               state_in = S_IDLE;
            end else if (first) begin
               ov_in    = 1'b1;
               state_in = S_IDLE;
            end else begin
               div_start = 1'b1;
               hold_in   = rd;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               ov_in    = 1'b1;
               has_in   = 1'b1;
               out_in   = hold_ff;
               avg_in   = (div_quot[SUM_W-1:32] != '0) ? 32'hffff_ffff : div_quot[31:0];
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         ov_ff    <= ov_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      addr_ff <= addr_in;
      hold_ff <= hold_in;
      acc_ff  <= acc_in;
      has_ff  <= has_in;
      out_ff  <= out_in;
      avg_ff  <= avg_in;
   end

   assign clearing         = state_ff == S_CLEAR;
   assign rsp_valid        = ov_ff;
   assign rsp_accepted     = acc_ff;
   assign rsp_bin_has_data = has_ff;
   assign rsp_bin_count    = out_ff.count;
   assign rsp_bin_min      = out_ff.min;
   assign rsp_bin_max      = out_ff.max;
   assign rsp_bin_sum      = out_ff.sum;
   assign rsp_bin_average  = avg_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/binned_min_max_mean_accumulator_top.sv
// top level of the binned min/max/mean accumulator
// depends on bmmma_pkg, bmmma_front, bmmma_back
`default_nettype none

// Usage
// Request channel: an item is taken at a clock edge with start high and busy
// low. req_op selects accumulate (one pulse) or read (one bin's statistics).
// Result channel: every item yields one transaction, shown on the rsp_ ports
// for one cycle with rsp_valid high; the receiver cannot stall it.
// Configuration: csr_valid/csr_ready write allow_errors (index 0) or
// wanted_mode (index 1); csr_ready is always high. Write only while idle.
// Responses: a rejected pulse answers without reading the bin memory, an
// accumulate or a read of an empty bin answers after the bin read, and a read
// of a filled bin also waits for the 64-step divider.
// Accumulates are paced by the read-modify-write of the bin memory, whose read
// data is registered; a two-entry queue decouples intake from the memory, so
// new items can be taken while the back end works on an earlier one.
// Reset: the bin memory, 2^(beam bits + azimuth bits) entries (131072 with
// default sizes), is cleared one entry a cycle; busy stays high meanwhile.
module binned_min_max_mean_accumulator_top #(
   parameter int AZIMUTH_BIN_COUNT = bmmma_pkg::AZIMUTH_BIN_COUNT_DEF,
   parameter int BEAM_COUNT        = bmmma_pkg::BEAM_COUNT_DEF,
   parameter int PULSES_PER_FRAME  = bmmma_pkg::PULSES_PER_FRAME_DEF,
   parameter int PULSE_FLAG_COUNT  = bmmma_pkg::PULSE_FLAG_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_op,
   input  wire logic [6:0]        req_pulse_index,
   input  wire logic [15:0]       req_azimuth,
   input  wire logic [31:0]       req_noise_energy,
   input  wire logic signed [7:0] req_cal_pulse_pos,
   input  wire logic [31:0]       req_frame_error,
   input  wire logic [15:0]       req_frame_quality,
   input  wire logic [12:0]       req_pulse_flag_mask,
   input  wire logic [7:0]        req_frame_mode,
   input  wire logic              req_read_beam,
   output logic                   rsp_valid,
   output logic                   rsp_accepted,
   output logic                   rsp_bin_has_data,
   output logic [31:0]            rsp_bin_count,
   output logic [31:0]            rsp_bin_min,
   output logic [31:0]            rsp_bin_max,
   output logic [63:0]            rsp_bin_sum,
   output logic [31:0]            rsp_bin_average,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [7:0]        csr_wdata
);
   import bmmma_pkg::*;

   localparam int AZW    = $clog2(AZIMUTH_BIN_COUNT);
   localparam int BW     = (BEAM_COUNT > 1) ? $clog2(BEAM_COUNT) : 1;
   localparam int ADDR_W = AZW + BW;

   logic              full;
   logic              clearing;
   logic              accept;
   logic              q_valid;
   logic              q_pop;
   item_type          q_item;
   logic [ADDR_W-1:0] q_addr;

   // intake handshake
   assign busy      = clearing || full;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   bmmma_front #(
      .AZIMUTH_BIN_COUNT(AZIMUTH_BIN_COUNT),
      .BEAM_COUNT       (BEAM_COUNT),
      .PULSES_PER_FRAME (PULSES_PER_FRAME),
      .PULSE_FLAG_COUNT (PULSE_FLAG_COUNT),
      .ADDR_W           (ADDR_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .full           (full),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .op             (req_op),
      .pulse_index    (req_pulse_index),
      .azimuth        (req_azimuth),
      .noise_energy   (req_noise_energy),
      .cal_pulse_pos  (req_cal_pulse_pos),
      .frame_error    (req_frame_error),
      .frame_quality  (req_frame_quality),
      .pulse_flag_mask(req_pulse_flag_mask),
      .frame_mode     (req_frame_mode),
      .read_beam      (req_read_beam),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_item         (q_item),
      .q_addr         (q_addr)
   );

   bmmma_back #(
      .ADDR_W(ADDR_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .clearing        (clearing),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_item          (q_item),
      .q_addr          (q_addr),
      .rsp_valid       (rsp_valid),
      .rsp_accepted    (rsp_accepted),
      .rsp_bin_has_data(rsp_bin_has_data),
      .rsp_bin_count   (rsp_bin_count),
      .rsp_bin_min     (rsp_bin_min),
      .rsp_bin_max     (rsp_bin_max),
      .rsp_bin_sum     (rsp_bin_sum),
      .rsp_bin_average (rsp_bin_average)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/bmmma_checker.sv
// port-level checker for the binned statistics accumulator, bound to the top
// depends on binned_min_max_mean_accumulator_top_defines.svh
`default_nettype none
`include "binned_min_max_mean_accumulator_top_defines.svh"

module bmmma_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_accepted,
   input wire logic        rsp_bin_has_data,
   input wire logic [31:0] rsp_bin_count,
   input wire logic [31:0] rsp_bin_min,
   input wire logic [31:0] rsp_bin_max,
   input wire logic [63:0] rsp_bin_sum,
   input wire logic [31:0] rsp_bin_average
);

   logic [2:0] pend_ff, pend_in;

   // transactions taken but not yet answered
   always_comb begin
      pend_in = pend_ff;
      if ((start && !busy) && !rsp_valid) begin
         pend_in = pend_ff + 3'd1;
      end else if (!(start && !busy) && rsp_valid) begin
         pend_in = pend_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `BMMMA_ASSERT_IMP(a_no_spurious_rsp, clock, reset, rsp_valid, pend_ff != 3'd0)
   `BMMMA_ASSERT_IMP(a_accum_no_stats, clock, reset, rsp_valid && rsp_accepted,
                     !rsp_bin_has_data && rsp_bin_count == 32'd0)
   `BMMMA_ASSERT_IMP(a_filled_bin_order, clock, reset, rsp_valid && rsp_bin_has_data,
                     rsp_bin_count != 32'd0 && rsp_bin_min <= rsp_bin_max)
   `BMMMA_ASSERT_IMP(a_empty_bin_zero, clock, reset, rsp_valid && !rsp_bin_has_data,
                     rsp_bin_sum == 64'd0 && rsp_bin_average == 32'd0)
   `BMMMA_ASSERT_NXT(a_accum_spacing, clock, reset, rsp_valid && rsp_accepted,
                     !(rsp_valid && rsp_accepted))

endmodule

bind binned_min_max_mean_accumulator_top bmmma_checker u_bmmma_checker (.*);

`default_nettype wire

FILE: tb/tb_binned_min_max_mean_accumulator_top.sv
// self-checking testbench for binned_min_max_mean_accumulator_top
// depends on bmmma_pkg and the accumulator rtl
`timescale 1ns / 1ps
`default_nettype none

module tb_binned_min_max_mean_accumulator_top;
   import bmmma_pkg::*;

   // one request transaction
   typedef struct {
      logic              op;
      logic [6:0]        pulse_index;
      logic [15:0]       azimuth;
      logic [31:0]       noise_energy;
      logic signed [7:0] cal_pulse_pos;
      logic [31:0]       frame_error;
      logic [15:0]       frame_quality;
      logic [12:0]       pulse_flag_mask;
      logic [7:0]        frame_mode;
      logic              read_beam;
   } pulse_req_type;

   // one response transaction
   typedef struct {
      logic        accepted;
      logic        has_data;
      logic [31:0] count;
      logic [31:0] min_dn;
      logic [31:0] max_dn;
      logic [63:0] sum;
      logic [31:0] average;
   } bin_rsp_type;

   // bin statistics predictor and response checker
   class bin_stats_scoreboard_type;
      bit [31:0]   count_of[int];
      bit [63:0]   sum_of[int];
      bit [31:0]   min_of[int];
      bit [31:0]   max_of[int];
      int          filled_bins[$];
      bin_rsp_type pending[$];
      bit          allow_errors;
      bit [7:0]    wanted_mode;
      int          errors;

      function bit pulse_passes(pulse_req_type r);
         int cal;
         int p;
         cal = r.cal_pulse_pos;
         p = r.pulse_index;
         if (!allow_errors && (r.frame_error != 0 || r.frame_quality != 0)) return 0;
         if (r.pulse_flag_mask != 0) return 0;
         if (r.frame_mode != wanted_mode) return 0;
         if (p >= PULSES_PER_FRAME_DEF) return 0;
         if (p == cal || p == cal - 1) return 0;
         return 1;
      endfunction

      // predict the response of one accepted request
      function void note_request(pulse_req_type r);
         bin_rsp_type e;
         int          bin;
         bit [64:0]   wide_sum;
         bit [63:0]   avg;
         e = '{default: '0};
         if (r.op == OP_ACCUMULATE) begin
            if (pulse_passes(r)) begin
               bin = int'({r.pulse_index[0], r.azimuth});
               if (!count_of.exists(bin) || count_of[bin] == 0) begin
                  count_of[bin] = 0;
                  sum_of[bin] = 0;
                  min_of[bin] = r.noise_energy;
                  max_of[bin] = r.noise_energy;
                  filled_bins.push_back(bin);
               end else begin
                  if (r.noise_energy < min_of[bin]) min_of[bin] = r.noise_energy;
                  if (r.noise_energy > max_of[bin]) max_of[bin] = r.noise_energy;
               end
               wide_sum = {1'b0, sum_of[bin]} + 65'(r.noise_energy);
               sum_of[bin] = wide_sum[64] ? '1 : wide_sum[63:0];
               if (count_of[bin] != '1) count_of[bin]++;
               e.accepted = 1;
            end
         end else begin
            bin = int'({r.read_beam, r.azimuth});
            if (count_of.exists(bin) && count_of[bin] != 0) begin
               avg = sum_of[bin] / 64'(count_of[bin]);
               e.has_data = 1;
               e.count = count_of[bin];
               e.min_dn = min_of[bin];
               e.max_dn = max_of[bin];
               e.sum = sum_of[bin];
               e.average = (avg > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : avg[31:0];
            end
         end
         pending.push_back(e);
      endfunction

      function void mismatch(string name, logic [63:0] exp_v, logic [63:0] got_v);
         $display("%0t mismatch %s: expected %h actual %h", $realtime, name, exp_v, got_v);
         errors++;
      endfunction

      // compare one observed response with the oldest prediction
      function void check_result(bin_rsp_type a);
         bin_rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected response transaction", $realtime);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.accepted !== e.accepted)
            mismatch("accepted", 64'(e.accepted), 64'(a.accepted));
         if (a.has_data !== e.has_data)
            mismatch("bin_has_data", 64'(e.has_data), 64'(a.has_data));
         if (a.count !== e.count) mismatch("bin_count", 64'(e.count), 64'(a.count));
         if (a.min_dn !== e.min_dn) mismatch("bin_min", 64'(e.min_dn), 64'(a.min_dn));
         if (a.max_dn !== e.max_dn) mismatch("bin_max", 64'(e.max_dn), 64'(a.max_dn));
         if (a.sum !== e.sum) mismatch("bin_sum", e.sum, a.sum);
         if (a.average !== e.average)
            mismatch("bin_average", 64'(e.average), 64'(a.average));
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 1000000;

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   logic              req_op = 0;
   logic [6:0]        req_pulse_index = 0;
   logic [15:0]       req_azimuth = 0;
   logic [31:0]       req_noise_energy = 0;
   logic signed [7:0] req_cal_pulse_pos = 0;
   logic [31:0]       req_frame_error = 0;
   logic [15:0]       req_frame_quality = 0;
   logic [12:0]       req_pulse_flag_mask = 0;
   logic [7:0]        req_frame_mode = 0;
   logic              req_read_beam = 0;
   logic              rsp_valid;
   logic              rsp_accepted;
   logic              rsp_bin_has_data;
   logic [31:0]       rsp_bin_count;
   logic [31:0]       rsp_bin_min;
   logic [31:0]       rsp_bin_max;
   logic [63:0]       rsp_bin_sum;
   logic [31:0]       rsp_bin_average;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic              csr_index = 0;
   logic [7:0]        csr_wdata = 0;

   bin_stats_scoreboard_type stats = new();
   int                  idle_pct;
   int                  activity;
   logic [15:0]         az_pool[8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                       16'h1234, 16'h7FFF, 16'hA5A5, 16'h0100};

   binned_min_max_mean_accumulator_top i_dut (.*);

   // clock generation
   initial begin
      forever #10 clock = ~clock;
   end

   // response monitor
   always @(posedge clock) begin
      bin_rsp_type a;
      if (!reset && rsp_valid) begin
         a.accepted = rsp_accepted;
         a.has_data = rsp_bin_has_data;
         a.count = rsp_bin_count;
         a.min_dn = rsp_bin_min;
         a.max_dn = rsp_bin_max;
         a.sum = rsp_bin_sum;
         a.average = rsp_bin_average;
         stats.check_result(a);
         activity++;
      end
   end

   // watchdog on cycles without any transaction
   initial begin
      int idle_cycles;
      int last_activity;
      idle_cycles = 0;
      last_activity = 0;
      forever begin
         @(posedge clock);
         if (activity != last_activity) idle_cycles = 0;
         else idle_cycles++;
         last_activity = activity;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // drive one request at a clock edge; ends at acceptance or after an idle gap
   task automatic send_request(pulse_req_type r);
      start <= 1;
      req_op <= r.op;
      req_pulse_index <= r.pulse_index;
      req_azimuth <= r.azimuth;
      req_noise_energy <= r.noise_energy;
      req_cal_pulse_pos <= r.cal_pulse_pos;
      req_frame_error <= r.frame_error;
      req_frame_quality <= r.frame_quality;
      req_pulse_flag_mask <= r.pulse_flag_mask;
      req_frame_mode <= r.frame_mode;
      req_read_beam <= r.read_beam;
      do @(posedge clock); while (busy);
      stats.note_request(r);
      activity++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // wait for all responses, then write one register
   task automatic write_csr(logic idx, logic [7:0] data);
      start <= 0;
      while (stats.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      activity++;
      if (idx == CSR_ALLOW_ERRORS) stats.allow_errors = data[0];
      else stats.wanted_mode = data;
   endtask

   // a clean pulse; it fails only if cal_pulse_pos is its index or index + 1
   function automatic pulse_req_type clean_pulse();
      pulse_req_type r;
      r = '{default: '0};
      r.op = OP_ACCUMULATE;
      r.pulse_index = 7'($urandom_range(PULSES_PER_FRAME_DEF - 1));
      r.azimuth = ($urandom_range(9) == 0) ? 16'($urandom) : az_pool[$urandom_range(7)];
      case ($urandom_range(9))
         0: r.noise_energy = 0;
         1: r.noise_energy = '1;
         default: r.noise_energy = $urandom;
      endcase
      r.cal_pulse_pos = 8'($urandom);
      r.frame_mode = stats.wanted_mode;
      r.read_beam = 1'($urandom);
      if (stats.allow_errors) begin
         r.frame_error = $urandom;
         r.frame_quality = 16'($urandom);
      end
      return r;
   endfunction

   // random item: mostly clean pulses, some reads of filled bins, some noise
   function automatic pulse_req_type random_item();
      pulse_req_type r;
      int            bin;
      int            pick;
      r = clean_pulse();
      pick = $urandom_range(99);
      if (pick < 15 && stats.filled_bins.size() != 0) begin
         bin = stats.filled_bins[$urandom_range(stats.filled_bins.size() - 1)];
         r.op = OP_READ;
         r.read_beam = bin[16];
         r.azimuth = bin[15:0];
         r.pulse_index = 7'($urandom);
         r.pulse_flag_mask = 13'($urandom);
         r.frame_error = $urandom;
      end else if (pick >= 80) begin
         case ($urandom_range(5))
            0: r.frame_error = $urandom;
            1: r.frame_quality = 16'($urandom);
            2: r.pulse_flag_mask = 13'($urandom);
            3: r.frame_mode = 8'($urandom);
            4: r.pulse_index = 7'($urandom);
            default: r.cal_pulse_pos = 8'(r.pulse_index + $urandom_range(1));
         endcase
      end
      return r;
   endfunction

   // read back a bin the predictor knows to be filled
   function automatic pulse_req_type read_of(logic beam, logic [15:0] az);
      pulse_req_type r;
      r = '{default: '0};
      r.op = OP_READ;
      r.read_beam = beam;
      r.azimuth = az;
      return r;
   endfunction

   // main sequence
   initial begin
      pulse_req_type r;
      logic [7:0] mode_list[4] = '{8'h00, 8'hFF, 8'h5A, 8'h01};
      idle_pct = 32;
      activity = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      do @(posedge clock); while (busy);

      // directed: extremes and each rejection reason
      write_csr(CSR_ALLOW_ERRORS, 8'd0);
      write_csr(CSR_WANTED_MODE, 8'h00);
      r = clean_pulse(); r.pulse_index = 0; r.azimuth = 0; r.noise_energy = 0;
      r.cal_pulse_pos = -128;
      send_request(r);
      r.noise_energy = '1; send_request(r);
      r.noise_energy = 32'h0000_1000; send_request(r);
      r = clean_pulse(); r.pulse_index = 99; r.azimuth = '1; r.noise_energy = '1;
      r.cal_pulse_pos = 127;
      send_request(r);
      r.frame_error = 32'h8000_0000; send_request(r);
      r.frame_error = 0; r.frame_quality = 16'h8000; send_request(r);
      r.frame_quality = 0; r.pulse_flag_mask = 13'h1000; send_request(r);
      r.pulse_flag_mask = 0; r.frame_mode = 8'hFF; send_request(r);
      r.frame_mode = stats.wanted_mode; r.pulse_index = 100; send_request(r);
      r.pulse_index = 127; send_request(r);
      r.pulse_index = 20; r.cal_pulse_pos = 20; send_request(r);
      r.cal_pulse_pos = 21; send_request(r);
      r.cal_pulse_pos = -1; r.pulse_index = 0; send_request(r);
      send_request(read_of(1'b0, 16'h0000));
      send_request(read_of(1'b1, 16'hFFFF));
      write_csr(CSR_ALLOW_ERRORS, 8'd1);
      write_csr(CSR_WANTED_MODE, 8'hFF);
      r = clean_pulse(); r.pulse_index = 1; r.azimuth = '1; r.noise_energy = 5;
      r.frame_error = '1; r.frame_quality = '1; r.cal_pulse_pos = -128;
      send_request(r);
      send_request(read_of(1'b1, 16'hFFFF));

      // random phases over several register settings
      for (int i = 0; i < 850; i++) begin
         if (i % 212 == 0) begin
            write_csr(CSR_ALLOW_ERRORS, 8'((i / 212) % 2));
            write_csr(CSR_WANTED_MODE, mode_list[(i / 212) % 4]);
         end
         idle_pct = (i < 283) ? 32 : (i < 566) ? 50 : 0;
         send_request(random_item());
      end
      start <= 0;

      // drain
      while (stats.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (stats.errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hw/rtl
hw/rtl/bmmma_pkg.sv
hw/rtl/bmmma_ram.sv
hw/rtl/bmmma_div.sv
hw/rtl/bmmma_front.sv
hw/rtl/bmmma_back.sv
hw/rtl/binned_min_max_mean_accumulator_top.sv
hw/rtl/bmmma_checker.sv
tb/tb_binned_min_max_mean_accumulator_top.sv
